@@ sv/assert_macros.svh @@
// assertion macros shared by the deadline timer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define MCDT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deadline timer assertion failed");

// condition must never be true outside reset
`define MCDT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("deadline timer forbidden condition seen");

`endif

@@ sv/mcdt_pkg.sv @@
// types, constants and helpers for the multi-channel deadline timer
`default_nettype none

package mcdt_pkg;

   // table geometry
   localparam int CHANNELS   = 16;
   localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // field widths
   localparam int TIME_W     = 32;
   localparam int CHAN_W     = 8;
   localparam int MIN_W      = 8;
   localparam int CHAN_OUT_W = 4;
   localparam int KIND_W     = 2;
   localparam int MINX_W     = MIN_W + 6;

   localparam logic [5:0]        SECONDS_PER_MINUTE = 6'd60;
   localparam logic [TIME_W-1:0] NO_TIMER           = '1;
   localparam logic [MIN_W-1:0]  MAX_MINUTES_RESET  = 8'd60;

   // request kinds
   localparam logic REQ_SET  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_SET_OK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET_REJECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ALARM      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE       = 2'd3;

   // commands from the sequencer to the expiry table
   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_idx;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      logic [TIME_W-1:0] wr_data;
      logic              clr_en;
      logic [IDX_W-1:0]  clr_idx;
   } tbl_cmd_type;

   // low bits of a table index as reported on the result channel
   function automatic logic [CHAN_OUT_W-1:0] chan_out_of(input logic [IDX_W-1:0] idx);
      logic [7:0] wide;
      wide = 8'(idx);
      return wide[CHAN_OUT_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ sv/mcdt_channels.sv @@
// handshake channel interfaces of the multi-channel deadline timer
`default_nettype none

// request items: set a channel timer or tick the time
interface mcdt_req_if;
   logic                            valid;
   logic                            ready;
   logic                            req_type;
   logic [mcdt_pkg::CHAN_W-1:0]     channel;
   logic [mcdt_pkg::MIN_W-1:0]      minutes;
   logic [mcdt_pkg::TIME_W-1:0]     now_seconds;

   modport source (output valid, req_type, channel, minutes, now_seconds, input ready);
   modport sink   (input valid, req_type, channel, minutes, now_seconds, output ready);
endinterface

// result items
interface mcdt_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mcdt_pkg::KIND_W-1:0]     result_kind;
   logic [mcdt_pkg::CHAN_OUT_W-1:0] channel_out;
   logic [mcdt_pkg::TIME_W-1:0]     end_time;
   logic                            last;

   modport source (output valid, result_kind, channel_out, end_time, last, input ready);
   modport sink   (input valid, result_kind, channel_out, end_time, last, output ready);
endinterface

// register write channel
interface mcdt_csr_if;
   logic                            valid;
   logic                            ready;
   logic [mcdt_pkg::MIN_W-1:0]      max_minutes;

   modport source (output valid, max_minutes, input ready);
   modport sink   (input valid, max_minutes, output ready);
endinterface

`default_nettype wire

@@ sv/multi_channel_deadline_timer.sv @@
// top level of the multi-channel deadline timer
//
//   channel  direction  payload
//   req_ch   in         req_type, channel, minutes, now_seconds
//   rsp_ch   out        result_kind, channel_out, end_time, last
//   csr_ch   in         max_minutes
//
// a set request goes to S_SET, which loads its result into the output register on a free slot
// a tick with nothing due leaves the sequencer in S_IDLE; a scanning tick runs S_READ, then
// S_CHECK per entry, then S_FINISH, one table read per entry through the single read port of the expiry memory
// a stalled result holds the sequencer at the entry or item that needs the output slot
// reset marks every table entry empty at once through per-entry valid bits
`default_nettype none

module multi_channel_deadline_timer (
   input  logic        clock,
   input  logic        reset,
   mcdt_req_if.sink    req_ch,
   mcdt_rsp_if.source  rsp_ch,
   mcdt_csr_if.sink    csr_ch
);

   logic [mcdt_pkg::MIN_W-1:0]  max_minutes_ff, max_minutes_in;
   mcdt_pkg::tbl_cmd_type       tbl_cmd;
   logic [mcdt_pkg::TIME_W-1:0] tbl_value;

   // duration limit register
   assign csr_ch.ready   = 1'b1;
   assign max_minutes_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.max_minutes : max_minutes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_minutes_ff <= mcdt_pkg::MAX_MINUTES_RESET;
      end else begin
         max_minutes_ff <= max_minutes_in;
      end
   end

   mcdt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .max_minutes (max_minutes_ff),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .tbl_cmd     (tbl_cmd),
      .tbl_value   (tbl_value)
   );

   mcdt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (tbl_cmd),
      .rd_value (tbl_value)
   );

endmodule

`default_nettype wire

@@ sv/mcdt_table.sv @@
// expiry table: synchronous memory with per-entry valid bits
`default_nettype none
`include "assert_macros.svh"

module mcdt_table (
   input  logic                          clock,
   input  logic                          reset,
   input  mcdt_pkg::tbl_cmd_type         cmd,
   output logic [mcdt_pkg::TIME_W-1:0]   rd_value
);

   logic [mcdt_pkg::TIME_W-1:0] mem [mcdt_pkg::CHANNELS];
   logic [mcdt_pkg::TIME_W-1:0] rd_data_ff;
   logic [mcdt_pkg::CHANNELS-1:0] valid_ff, valid_in;
   logic rd_hit_ff, rd_hit_in;

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_idx] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_idx];
      end
   end

   // valid bits: set on write, cleared when an alarm retires the entry
   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.wr_idx] = 1'b1;
      end
      if (cmd.clr_en) begin
         valid_in[cmd.clr_idx] = 1'b0;
      end
      rd_hit_in = cmd.rd_en ? valid_ff[cmd.rd_idx] : rd_hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   // an entry never written or already expired reads as no timer
   assign rd_value = rd_hit_ff ? rd_data_ff : mcdt_pkg::NO_TIMER;

   `MCDT_NEVER(a_wr_and_clr, clock, reset, cmd.wr_en && cmd.clr_en)

endmodule

`default_nettype wire

@@ sv/mcdt_ctrl.sv @@
// sequencer: set requests, tick scans and the result register
`default_nettype none
`include "assert_macros.svh"

module mcdt_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mcdt_pkg::MIN_W-1:0]    max_minutes,
   mcdt_req_if.sink                      req_ch,
   mcdt_rsp_if.source                    rsp_ch,
   output mcdt_pkg::tbl_cmd_type         tbl_cmd,
   input  logic [mcdt_pkg::TIME_W-1:0]   tbl_value
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SET    = 5'b00010,
      S_READ   = 5'b00100,
      S_CHECK  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [mcdt_pkg::TIME_W-1:0] now_ff, now_in;
   logic [mcdt_pkg::CHAN_W-1:0] chan_ff, chan_in;
   logic [mcdt_pkg::MIN_W-1:0]  mins_ff, mins_in;
   logic [mcdt_pkg::TIME_W-1:0] earliest_ff, earliest_in;
   logic [mcdt_pkg::TIME_W-1:0] next_ff, next_in;
   logic                        fired_ff, fired_in;
   logic [mcdt_pkg::IDX_W-1:0]  idx_ff, idx_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [mcdt_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [mcdt_pkg::CHAN_OUT_W-1:0] chout_ff, chout_in;
   logic [mcdt_pkg::TIME_W-1:0]     end_ff, end_in;
   logic                            last_ff, last_in;

   logic                        req_fire;
   logic                        slot_free;
   logic                        load;
   logic [mcdt_pkg::MINX_W-1:0] mins_x60;
   logic [mcdt_pkg::TIME_W-1:0] set_end;
   logic                        set_ok;
   logic                        expired;
   logic                        idx_last;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   // set request arithmetic on the latched item
   assign mins_x60 = mcdt_pkg::MINX_W'(mins_ff) * mcdt_pkg::MINX_W'(mcdt_pkg::SECONDS_PER_MINUTE);
   assign set_end  = now_ff + mcdt_pkg::TIME_W'(mins_x60);
   assign set_ok   = (chan_ff < mcdt_pkg::CHAN_W'(mcdt_pkg::CHANNELS)) &&
                     (mins_ff <= max_minutes) && (now_ff != '0);

   // scan compare on the entry returned by the previous table read
   assign expired  = tbl_value < now_ff;
   assign idx_last = (idx_ff == mcdt_pkg::IDX_W'(mcdt_pkg::CHANNELS - 1));

   always_comb begin
      state_in    = state_ff;
      now_in      = now_ff;
      chan_in     = chan_ff;
      mins_in     = mins_ff;
      earliest_in = earliest_ff;
      next_in     = next_ff;
      fired_in    = fired_ff;
      idx_in      = idx_ff;
      load        = 1'b0;
      kind_in     = kind_ff;
      chout_in    = chout_ff;
      end_in      = end_ff;
      last_in     = last_ff;
      tbl_cmd     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               now_in  = req_ch.now_seconds;
               chan_in = req_ch.channel;
               mins_in = req_ch.minutes;
               if (req_ch.req_type == mcdt_pkg::REQ_SET) begin
                  state_in = S_SET;
               end else if (earliest_ff < req_ch.now_seconds) begin
                  next_in  = mcdt_pkg::NO_TIMER;
                  fired_in = 1'b0;
                  idx_in   = '0;
                  state_in = S_READ;
               end
            end
         end
         // one result per set request, table written for an accepted set when its result is loaded
         S_SET: begin
            if (slot_free) begin
               load     = 1'b1;
               last_in  = 1'b1;
               state_in = S_IDLE;
               if (set_ok) begin
                  kind_in         = mcdt_pkg::KIND_SET_OK;
                  chout_in        = chan_ff[mcdt_pkg::CHAN_OUT_W-1:0];
                  end_in          = set_end;
                  tbl_cmd.wr_en   = 1'b1;
                  tbl_cmd.wr_idx  = chan_ff[mcdt_pkg::IDX_W-1:0];
                  tbl_cmd.wr_data = set_end;
                  if (set_end < earliest_ff) begin
                     earliest_in = set_end;
                  end
               end else begin
                  kind_in  = mcdt_pkg::KIND_SET_REJECT;
                  chout_in = '0;
                  end_in   = '0;
               end
            end
         end
         // first read of the scan
         S_READ: begin
            tbl_cmd.rd_en  = 1'b1;
            tbl_cmd.rd_idx = idx_ff;
            state_in       = S_CHECK;
         end
         // check one entry, read the next one as we move on
         S_CHECK: begin
            if (!expired || slot_free) begin
               if (expired) begin
                  load            = 1'b1;
                  kind_in         = mcdt_pkg::KIND_ALARM;
                  chout_in        = mcdt_pkg::chan_out_of(idx_ff);
                  end_in          = tbl_value;
                  last_in         = 1'b0;
                  fired_in        = 1'b1;
                  tbl_cmd.clr_en  = 1'b1;
                  tbl_cmd.clr_idx = idx_ff;
               end else if (tbl_value < next_ff) begin
                  next_in = tbl_value;
               end
               if (idx_last) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in         = idx_ff + 1'b1;
                  tbl_cmd.rd_en  = 1'b1;
                  tbl_cmd.rd_idx = idx_ff + 1'b1;
               end
            end
         end
         // new earliest expiry and, if any alarm fired, the closing item
         S_FINISH: begin
            if (!fired_ff) begin
               earliest_in = next_ff;
               state_in    = S_IDLE;
            end else if (slot_free) begin
               earliest_in = next_ff;
               load        = 1'b1;
               kind_in     = mcdt_pkg::KIND_DONE;
               chout_in    = '0;
               end_in      = '0;
               last_in     = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         earliest_ff  <= mcdt_pkg::NO_TIMER;
         rsp_valid_ff <= 1'b0;
         fired_ff     <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         earliest_ff  <= earliest_in;
         rsp_valid_ff <= rsp_valid_in;
         fired_ff     <= fired_in;
         idx_ff       <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff   <= now_in;
      chan_ff  <= chan_in;
      mins_ff  <= mins_in;
      next_ff  <= next_in;
      kind_ff  <= load ? kind_in  : kind_ff;
      chout_ff <= load ? chout_in : chout_ff;
      end_ff   <= load ? end_in   : end_ff;
      last_ff  <= load ? last_in  : last_ff;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.channel_out = chout_ff;
   assign rsp_ch.end_time    = end_ff;
   assign rsp_ch.last        = last_ff;

   `MCDT_ASSERT(a_earliest_only_lowers, clock, reset,
      ($past(state_ff) != S_FINISH) |-> (earliest_ff <= $past(earliest_ff)))
   `MCDT_ASSERT(a_result_from_work, clock, reset,
      $rose(rsp_valid_ff) |-> ($past(state_ff) != S_IDLE))
   `MCDT_ASSERT(a_scan_starts_at_zero, clock, reset,
      (state_ff == S_READ) |-> (idx_ff == '0))

endmodule

`default_nettype wire
